[src/dppt_pkg.sv]
// Shared types and constants for the depth pixel to point transform.
package dppt_pkg;

    // Pixel coordinate and depth widths honored from the incoming word.
    localparam int COORD_BITS = 12;
    localparam int DEPTH_BITS = 16;

    localparam logic [11:0] COORD_MASK = 12'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic [15:0] DEPTH_MASK = 16'((64'd1 << DEPTH_BITS) - 64'd1);

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Back-end pipeline stages, the output register included.
    localparam int NSTG = 8;

    // Register indexes on the configuration port (byte address 8*index).
    typedef enum logic [2:0] {
        REG_PRINCIPAL   = 3'd0,
        REG_INV_FX      = 3'd1,
        REG_INV_FY      = 3'd2,
        REG_ROW_X       = 3'd3,
        REG_ROW_Y       = 3'd4,
        REG_ROW_Z       = 3'd5,
        REG_MAX_DEPTH   = 3'd6
    } t_reg_idx;

    localparam logic [63:0] ROW_X_RST     = 64'h0000_0000_0000_4000;
    localparam logic [63:0] ROW_Y_RST     = 64'h0000_0000_4000_0000;
    localparam logic [63:0] ROW_Z_RST     = 64'h0000_4000_0000_0000;
    localparam logic [15:0] MAX_DEPTH_RST = 16'd7000;

    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [31:0] inv_fx;
        logic [31:0] inv_fy;
        logic [63:0] row_x;
        logic [63:0] row_y;
        logic [63:0] row_z;
        logic [15:0] max_depth;
    } t_cfg;

    // One classified pixel waiting for the back end.
    typedef struct packed {
        logic [15:0] ax;      // |col*16 - cx|
        logic        sx;
        logic [15:0] ay;      // |row*16 - cy|
        logic        sy;
        logic [15:0] depth;
        logic        pvalid;
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic [7:0]  c3;
    } t_entry;

    // Items that ride along the back-end pipeline untouched.
    typedef struct packed {
        logic       pvalid;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
    } t_side;

endpackage

[src/dppt_cfg.sv]
// Configuration register file with an APB-style port.
module dppt_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    output dppt_pkg::t_cfg o_cfg
);
    import dppt_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[5:3]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cx        <= '0;
            r_cfg.cy        <= '0;
            r_cfg.inv_fx    <= '0;
            r_cfg.inv_fy    <= '0;
            r_cfg.row_x     <= ROW_X_RST;
            r_cfg.row_y     <= ROW_Y_RST;
            r_cfg.row_z     <= ROW_Z_RST;
            r_cfg.max_depth <= MAX_DEPTH_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_PRINCIPAL: begin
                    r_cfg.cx <= pwdata[15:0];
                    r_cfg.cy <= pwdata[31:16];
                end
                REG_INV_FX:    r_cfg.inv_fx    <= pwdata[31:0];
                REG_INV_FY:    r_cfg.inv_fy    <= pwdata[31:0];
                REG_ROW_X:     r_cfg.row_x     <= pwdata;
                REG_ROW_Y:     r_cfg.row_y     <= pwdata;
                REG_ROW_Z:     r_cfg.row_z     <= pwdata;
                REG_MAX_DEPTH: r_cfg.max_depth <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PRINCIPAL: prdata = {32'd0, r_cfg.cy, r_cfg.cx};
            REG_INV_FX:    prdata = {32'd0, r_cfg.inv_fx};
            REG_INV_FY:    prdata = {32'd0, r_cfg.inv_fy};
            REG_ROW_X:     prdata = r_cfg.row_x;
            REG_ROW_Y:     prdata = r_cfg.row_y;
            REG_ROW_Z:     prdata = r_cfg.row_z;
            REG_MAX_DEPTH: prdata = {48'd0, r_cfg.max_depth};
            default:       prdata = '0;
        endcase
    end

endmodule

[src/dppt_front.sv]
// Front end: accept pixel words, check depth and form offsets from the principal point.
module dppt_front (
    input  logic             i_tvalid,
    output logic             o_tready,
    input  logic [63:0]      i_tdata,
    input  dppt_pkg::t_cfg   i_cfg,
    input  logic             i_full,
    output logic             o_push,
    output dppt_pkg::t_entry o_entry
);
    import dppt_pkg::*;

    logic [15:0] w_depth;
    logic [11:0] w_col;
    logic [11:0] w_row;
    logic [16:0] w_dx;
    logic [16:0] w_dy;
    logic [16:0] w_ndx;
    logic [16:0] w_ndy;

    assign o_tready = !i_full;
    assign o_push   = i_tvalid && !i_full;

    assign w_depth = i_tdata[15:0] & DEPTH_MASK;
    assign w_col   = i_tdata[27:16] & COORD_MASK;
    assign w_row   = i_tdata[39:28] & COORD_MASK;

    // Offset in Q.4 pixels, kept as sign and magnitude
    assign w_dx  = {1'b0, w_col, 4'd0} - {1'b0, i_cfg.cx};
    assign w_dy  = {1'b0, w_row, 4'd0} - {1'b0, i_cfg.cy};
    assign w_ndx = -w_dx;
    assign w_ndy = -w_dy;

    always_comb begin
        o_entry.sx     = w_dx[16];
        o_entry.ax     = w_dx[16] ? w_ndx[15:0] : w_dx[15:0];
        o_entry.sy     = w_dy[16];
        o_entry.ay     = w_dy[16] ? w_ndy[15:0] : w_dy[15:0];
        o_entry.depth  = w_depth;
        o_entry.pvalid = (w_depth <= i_cfg.max_depth);
        o_entry.c1     = i_tdata[47:40];
        o_entry.c2     = i_tdata[55:48];
        o_entry.c3     = i_tdata[63:56];
    end

endmodule

[src/dppt_fifo.sv]
// Short queue that decouples the front end from the back end.
module dppt_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dppt_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output dppt_pkg::t_entry o_entry
);
    import dppt_pkg::*;

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];

    assign n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[src/dppt_back.sv]
// Back end: back-projection, rigid transform, rounding and saturation pipeline.
module dppt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    output logic             o_pop,
    input  dppt_pkg::t_entry i_entry,
    input  dppt_pkg::t_cfg   i_cfg,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [119:0]     o_tdata,
    output logic [1:0]       o_tuser
);
    import dppt_pkg::*;

    logic [NSTG-1:0] r_vld;
    t_side           r_side [NSTG-1];
    logic            w_adv;

    // stage 1..3 operands
    logic [31:0] r_magx, r_magy;
    logic [63:0] r_px, r_py;
    logic [36:0] r_rx, r_ry;
    logic        r_sx1, r_sy1, r_sx2, r_sy2, r_sx3, r_sy3;
    logic [15:0] r_dep1, r_dep2, r_dep3;
    logic [64:0] w_sumx, w_sumy;

    // stage 4..7
    logic signed [37:0] r_camx, r_camy;
    logic signed [24:0] r_camz;
    logic signed [53:0] r_prod [3][3];
    logic signed [15:0] r_tr [3];
    logic signed [55:0] r_pa [3];
    logic signed [55:0] r_pb [3];
    logic signed [55:0] r_sum [3];

    logic [63:0]        w_row [3];
    logic signed [55:0] w_rnd [3];
    logic [31:0]        w_crd [3];
    logic [2:0]         w_ovf;

    // output register
    logic [119:0] r_tdata;
    logic [1:0]   r_tuser;

    assign w_row[0] = i_cfg.row_x;
    assign w_row[1] = i_cfg.row_y;
    assign w_row[2] = i_cfg.row_z;

    // Advance the whole pipeline unless the output word is held
    assign w_adv    = !r_vld[NSTG-1] || i_tready;
    assign o_pop    = w_adv && !i_empty;
    assign o_tvalid = r_vld[NSTG-1];
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;

    // Round half up from Q.28 scaling
    assign w_sumx = {1'b0, r_px} + 65'd134217728;
    assign w_sumy = {1'b0, r_py} + 65'd134217728;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rnd[i] = (r_sum[i] + 56'sd8192) >>> 14;
            w_ovf[i] = (w_rnd[i][55:31] != {25{w_rnd[i][55]}});
            if (w_ovf[i]) begin
                w_crd[i] = w_rnd[i][55] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                w_crd[i] = w_rnd[i][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= '{pvalid: i_entry.pvalid, c1: i_entry.c1,
                           c2: i_entry.c2, c3: i_entry.c3};
            for (int k = 1; k < NSTG - 1; k++) begin
                r_side[k] <= r_side[k-1];
            end

            // offset magnitude times depth
            r_magx <= 32'(i_entry.ax) * 32'(i_entry.depth);
            r_magy <= 32'(i_entry.ay) * 32'(i_entry.depth);
            r_sx1  <= i_entry.sx;
            r_sy1  <= i_entry.sy;
            r_dep1 <= i_entry.depth;

            // times focal reciprocal
            r_px   <= 64'(r_magx) * 64'(i_cfg.inv_fx);
            r_py   <= 64'(r_magy) * 64'(i_cfg.inv_fy);
            r_sx2  <= r_sx1;
            r_sy2  <= r_sy1;
            r_dep2 <= r_dep1;

            r_rx   <= w_sumx[64:28];
            r_ry   <= w_sumy[64:28];
            r_sx3  <= r_sx2;
            r_sy3  <= r_sy2;
            r_dep3 <= r_dep2;

            // restore sign
            r_camx <= r_sx3 ? -$signed({1'b0, r_rx}) : $signed({1'b0, r_rx});
            r_camy <= r_sy3 ? -$signed({1'b0, r_ry}) : $signed({1'b0, r_ry});
            r_camz <= $signed({1'b0, r_dep3, 8'd0});

            for (int i = 0; i < 3; i++) begin
                r_prod[i][0] <= 54'($signed(w_row[i][15:0]))  * 54'(r_camx);
                r_prod[i][1] <= 54'($signed(w_row[i][31:16])) * 54'(r_camy);
                r_prod[i][2] <= 54'($signed(w_row[i][47:32])) * 54'(r_camz);
                r_tr[i]      <= $signed(w_row[i][63:48]);

                r_pa[i]  <= 56'(r_prod[i][0]) + 56'(r_prod[i][1]);
                r_pb[i]  <= 56'(r_prod[i][2]) + (56'(r_tr[i]) <<< 22);
                r_sum[i] <= r_pa[i] + r_pb[i];
            end

            // drop the coordinates of an out-of-range pixel, keep the colour
            if (r_side[NSTG-2].pvalid) begin
                r_tdata <= {r_side[NSTG-2].c3, r_side[NSTG-2].c2, r_side[NSTG-2].c1,
                            w_crd[2], w_crd[1], w_crd[0]};
                r_tuser <= {|w_ovf, 1'b1};
            end else begin
                r_tdata <= {r_side[NSTG-2].c3, r_side[NSTG-2].c2, r_side[NSTG-2].c1,
                            96'd0};
                r_tuser <= 2'b00;
            end
        end
    end

endmodule

[src/depth_pixel_to_point_transform.sv]
// Depth pixel to transformed point: top level tying front end, queue, back end and registers.
// Path: an accepted input word is written to the queue, then passes the eight back-end stages;
//   the last is the output register.
// Throughput: one word per clock; the back-end pipeline holds only when the output word waits.
// s_axis_tready drops only when the four-entry queue is full.
// Reset (synchronous, active low) empties the queue and pipeline and loads the register defaults.
module depth_pixel_to_point_transform (
    input  logic          i_clk,
    input  logic          i_rst_n,

    // pixel stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [15:0] depth_mm, [27:16] column, [39:28] row_index,
    // [47:40] colour_first, [55:48] colour_second, [63:56] colour_third
    input  logic [63:0]   s_axis_tdata,

    // point stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [31:0] point_x, [63:32] point_y, [95:64] point_z, [103:96] out_colour_first,
    // [111:104] out_colour_second, [119:112] out_colour_third
    output logic [119:0]  m_axis_tdata,
    // [0] point_valid, [1] saturated
    output logic [1:0]    m_axis_tuser,

    // register port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    import dppt_pkg::*;

    t_cfg   w_cfg;
    t_entry w_push_entry;
    t_entry w_pop_entry;
    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;

    // Registers: principal point, focal reciprocals, transform rows, depth limit
    dppt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Accept a pixel word whenever the queue has room and classify its depth
    dppt_front u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_cfg    (w_cfg),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    // Hold classified pixels so either side can stall on its own
    dppt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_entry (w_pop_entry)
    );

    // Back-project, transform, round and saturate; one pixel per clock unless the output word is held
    dppt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .i_entry  (w_pop_entry),
        .i_cfg    (w_cfg),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

endmodule

[test/dppt_checker.sv]
// Point stream checker: tracks register writes, predicts each point and compares the output.
`timescale 1ns / 100ps

module dppt_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,

    input  logic          i_s_tvalid,
    input  logic          i_s_tready,
    input  logic [63:0]   i_s_tdata,

    input  logic          i_m_tvalid,
    input  logic          i_m_tready,
    input  logic [119:0]  i_m_tdata,
    input  logic [1:0]    i_m_tuser,

    input  logic          i_psel,
    input  logic          i_penable,
    input  logic          i_pwrite,
    input  logic          i_pready,
    input  logic [5:0]    i_paddr,
    input  logic [63:0]   i_pwdata,

    output int            o_mismatches,
    output int            o_pending,
    output int            o_points,
    output int            o_invalid,
    output int            o_clipped
);
    import dppt_pkg::*;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        valid;
        logic        clip;
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic [7:0]  c3;
    } t_point;

    t_cfg   cfg;
    t_point pending_points[$];
    int     mismatch_count = 0;
    int     point_count    = 0;
    int     invalid_count  = 0;
    int     clipped_count  = 0;

    // Camera-space axis in Q.8 mm: (coord*16 - centre) * depth * inv_f / 2^28,
    // rounded half away from zero.
    function automatic longint backproject_axis(logic [11:0] coord, logic [15:0] centre,
                                                logic [15:0] depth, logic [31:0] inv_f);
        longint              offset;
        longint unsigned     mag;
        logic [95:0]         prod;
        longint unsigned     r;
        offset = longint'({48'd0, coord, 4'd0}) - longint'({48'd0, centre});
        if (offset < 0) begin
            mag = -offset;
        end else begin
            mag = offset;
        end
        mag  = mag * {48'd0, depth};
        prod = {32'd0, mag} * {64'd0, inv_f} + (96'd1 << 27);
        r    = prod[91:28];
        return (offset < 0) ? -longint'(r) : longint'(r);
    endfunction

    // One transform row: Q.22 sum, round half up to Q.8, clip to 32 bits.
    // Bit 32 of the return flags a clip.
    function automatic logic [32:0] transform_axis(logic [63:0] row, longint cam_x,
                                                   longint cam_y, longint cam_z);
        longint acc;
        longint q;
        logic   clip;
        acc = longint'($signed(row[15:0])) * cam_x
            + longint'($signed(row[31:16])) * cam_y
            + longint'($signed(row[47:32])) * cam_z
            + (longint'($signed(row[63:48])) <<< 22);
        q    = (acc + 64'sd8192) >>> 14;
        clip = 1'b0;
        if (q > 64'sd2147483647) begin
            q    = 64'sd2147483647;
            clip = 1'b1;
        end
        if (q < -64'sd2147483648) begin
            q    = -64'sd2147483648;
            clip = 1'b1;
        end
        return {clip, q[31:0]};
    endfunction

    function automatic t_point predict_point(logic [63:0] word);
        logic [15:0] depth;
        logic [11:0] col;
        logic [11:0] row;
        longint      cam_x;
        longint      cam_y;
        longint      cam_z;
        logic [32:0] ox;
        logic [32:0] oy;
        logic [32:0] oz;
        t_point      p;
        depth = word[15:0] & DEPTH_MASK;
        col   = word[27:16] & COORD_MASK;
        row   = word[39:28] & COORD_MASK;
        p     = '0;
        p.c1  = word[47:40];
        p.c2  = word[55:48];
        p.c3  = word[63:56];
        // depth beyond the limit: zero point, colors still pass
        if (depth > cfg.max_depth) begin
            return p;
        end
        cam_x   = backproject_axis(col, cfg.cx, depth, cfg.inv_fx);
        cam_y   = backproject_axis(row, cfg.cy, depth, cfg.inv_fy);
        cam_z   = longint'({48'd0, depth}) * 256;
        ox      = transform_axis(cfg.row_x, cam_x, cam_y, cam_z);
        oy      = transform_axis(cfg.row_y, cam_x, cam_y, cam_z);
        oz      = transform_axis(cfg.row_z, cam_x, cam_y, cam_z);
        p.x     = ox[31:0];
        p.y     = oy[31:0];
        p.z     = oz[31:0];
        p.valid = 1'b1;
        p.clip  = ox[32] | oy[32] | oz[32];
        return p;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        if (mismatch_count < 20) begin
            $display("MISMATCH point %0d %s: got %0d, expected %0d",
                     point_count, field, got, want);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_point want;
        t_point got;
        if (!i_rst_n) begin
            cfg           = '0;
            cfg.row_x     = ROW_X_RST;
            cfg.row_y     = ROW_Y_RST;
            cfg.row_z     = ROW_Z_RST;
            cfg.max_depth = MAX_DEPTH_RST;
            pending_points.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[5:3]))
                    REG_PRINCIPAL: {cfg.cy, cfg.cx} = i_pwdata[31:0];
                    REG_INV_FX:    cfg.inv_fx       = i_pwdata[31:0];
                    REG_INV_FY:    cfg.inv_fy       = i_pwdata[31:0];
                    REG_ROW_X:     cfg.row_x        = i_pwdata;
                    REG_ROW_Y:     cfg.row_y        = i_pwdata;
                    REG_ROW_Z:     cfg.row_z        = i_pwdata;
                    REG_MAX_DEPTH: cfg.max_depth    = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                pending_points.push_back(predict_point(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.x     = i_m_tdata[31:0];
                got.y     = i_m_tdata[63:32];
                got.z     = i_m_tdata[95:64];
                got.c1    = i_m_tdata[103:96];
                got.c2    = i_m_tdata[111:104];
                got.c3    = i_m_tdata[119:112];
                got.valid = i_m_tuser[0];
                got.clip  = i_m_tuser[1];
                if (pending_points.size() == 0) begin
                    report_mismatch("word with no pixel pending",
                                    longint'($signed(got.x)), 64'sd0);
                end else begin
                    want = pending_points.pop_front();
                    if (got.x !== want.x)
                        report_mismatch("point_x", longint'($signed(got.x)),
                                        longint'($signed(want.x)));
                    if (got.y !== want.y)
                        report_mismatch("point_y", longint'($signed(got.y)),
                                        longint'($signed(want.y)));
                    if (got.z !== want.z)
                        report_mismatch("point_z", longint'($signed(got.z)),
                                        longint'($signed(want.z)));
                    if (got.valid !== want.valid)
                        report_mismatch("point_valid", longint'(got.valid),
                                        longint'(want.valid));
                    if (got.clip !== want.clip)
                        report_mismatch("saturated", longint'(got.clip), longint'(want.clip));
                    if (got.c1 !== want.c1)
                        report_mismatch("out_colour_first", longint'(got.c1),
                                        longint'(want.c1));
                    if (got.c2 !== want.c2)
                        report_mismatch("out_colour_second", longint'(got.c2),
                                        longint'(want.c2));
                    if (got.c3 !== want.c3)
                        report_mismatch("out_colour_third", longint'(got.c3),
                                        longint'(want.c3));
                    if (!want.valid) invalid_count++;
                    if (want.clip) clipped_count++;
                end
                point_count++;
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= pending_points.size();
        o_points     <= point_count;
        o_invalid    <= invalid_count;
        o_clipped    <= clipped_count;
    end

endmodule

[test/testbench.sv]
// Stimulus and verdict for the depth pixel to point transform.
`timescale 1ns / 100ps

module testbench;
    import dppt_pkg::*;

    // Slack for the pipeline tail after the last predicted point has come out.
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_PIXELS  = 425;

    // Register settings the run steps through.
    typedef enum int {
        CFG_CAMERA,
        CFG_RANDOM,
        CFG_HIGH,
        CFG_LOW
    } t_setting;

    // Packs straight onto s_axis_tdata: depth in the lowest bits.
    typedef struct packed {
        logic [7:0]  c3;
        logic [7:0]  c2;
        logic [7:0]  c1;
        logic [11:0] row;
        logic [11:0] col;
        logic [15:0] depth;
    } t_pixel;

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    // [15:0] depth_mm, [27:16] column, [39:28] row_index,
    // [47:40] colour_first, [55:48] colour_second, [63:56] colour_third
    logic [63:0]   s_axis_tdata  = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    // [31:0] point_x, [63:32] point_y, [95:64] point_z, [103:96] out_colour_first,
    // [111:104] out_colour_second, [119:112] out_colour_third
    logic [119:0]  m_axis_tdata;
    // [0] point_valid, [1] saturated
    logic [1:0]    m_axis_tuser;
    logic          psel          = 1'b0;
    logic          penable       = 1'b0;
    logic          pwrite        = 1'b0;
    logic [5:0]    paddr         = '0;
    logic [63:0]   pwdata        = '0;
    logic [63:0]   prdata;
    logic          pready;

    int            mismatches;
    int            pending;
    int            points;
    int            invalid_points;
    int            clipped_points;

    int            cycle_count   = 0;
    int            pixels_sent   = 0;
    int            send_idle     = 0;
    int            recv_stall    = 0;
    logic [31:0]   cur_pp        = '0;
    logic [15:0]   cur_max       = MAX_DEPTH_RST;

    depth_pixel_to_point_transform u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    dppt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_points     (points),
        .o_invalid    (invalid_points),
        .o_clipped    (clipped_points)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stall the point stream at the rate the current phase asks for.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Write one register: setup cycle, then access cycle until pready.
    // Return psel low before the next write so back-to-back writes never retoggle psel in one step.
    task automatic apb_write(input t_reg_idx idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold the pixel stream low until every predicted point has come out,
    // then let the pipeline tail pass.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Offer one pixel word after a random gap and hold it until accepted.
    task automatic send_pixel(input t_pixel px);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        pixels_sent++;
    endtask

    function automatic t_pixel pixel_of(logic [15:0] depth, logic [11:0] col, logic [11:0] row,
                                        logic [7:0] c1, logic [7:0] c2, logic [7:0] c3);
        t_pixel p;
        p.depth = depth;
        p.col   = col;
        p.row   = row;
        p.c1    = c1;
        p.c2    = c2;
        p.c3    = c3;
        return p;
    endfunction

    // Mostly depths within the limit, with weight on the limit itself and
    // just past it; columns and rows sometimes pinned to the frame edges.
    function automatic t_pixel random_pixel();
        t_pixel      p;
        int unsigned pick;
        p    = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 60) begin
            p.depth = 16'($urandom_range(0, cur_max));
        end else if (pick < 70) begin
            p.depth = cur_max;
        end else if (pick < 78) begin
            p.depth = (cur_max == 16'hFFFF) ? cur_max : cur_max + 16'd1;
        end
        if ($urandom_range(9) == 0) p.col = $urandom_range(1) ? 12'hFFF : 12'h000;
        if ($urandom_range(9) == 0) p.row = $urandom_range(1) ? 12'hFFF : 12'h000;
        return p;
    endfunction

    // Load every register for one setting; call only while the block is idle.
    task automatic load_settings(input t_setting mode);
        logic [31:0] pp;
        logic [31:0] ifx;
        logic [31:0] ify;
        logic [63:0] rows [3];
        logic [15:0] lim;
        case (mode)
            CFG_CAMERA: begin
                // principal point near the frame center, focal 400..700 px,
                // rotation close to identity, small translation
                pp  = {16'($urandom_range(160, 320) * 16 + $urandom_range(15)),
                       16'($urandom_range(240, 480) * 16 + $urandom_range(15))};
                ifx = 32'((64'd1 << 32) / $urandom_range(400, 700));
                ify = 32'((64'd1 << 32) / $urandom_range(400, 700));
                for (int k = 0; k < 3; k++) begin
                    rows[k][63:48] = 16'($urandom_range(0, 4000)) - 16'd2000;
                    for (int j = 0; j < 3; j++) begin
                        rows[k][16*j +: 16] = (j == k)
                            ? 16'h4000 - 16'($urandom_range(0, 300))
                            : 16'($urandom_range(0, 1200)) - 16'd600;
                    end
                end
                lim = 16'($urandom_range(4000, 10000));
            end
            CFG_RANDOM: begin
                pp  = $urandom;
                ifx = $urandom;
                ify = $urandom;
                for (int k = 0; k < 3; k++) rows[k] = {$urandom, $urandom};
                lim = 16'($urandom_range(2000, 65535));
            end
            CFG_HIGH: begin
                // largest gains and offsets: drives the outputs to the positive rail
                pp  = 32'h0000_0000;
                ifx = 32'hFFFF_FFFF;
                ify = 32'hFFFF_FFFF;
                for (int k = 0; k < 3; k++) rows[k] = 64'h7FFF_7FFF_7FFF_7FFF;
                lim = 16'hFFFF;
            end
            default: begin
                // factors aimed at the negative rail, most negative offsets, principal point at the top
                pp      = 32'hFFFF_FFFF;
                ifx     = 32'hFFFF_FFFF;
                ify     = 32'hFFFF_FFFF;
                rows[0] = 64'h8000_0000_0000_8000;
                rows[1] = 64'h8000_0000_7FFF_0000;
                rows[2] = 64'h8000_8000_0000_0000;
                lim     = 16'($urandom_range(1000, 65534));
            end
        endcase
        apb_write(REG_PRINCIPAL, {32'd0, pp});
        apb_write(REG_INV_FX, {32'd0, ifx});
        apb_write(REG_INV_FY, {32'd0, ify});
        apb_write(REG_ROW_X, rows[0]);
        apb_write(REG_ROW_Y, rows[1]);
        apb_write(REG_ROW_Z, rows[2]);
        apb_write(REG_MAX_DEPTH, {48'd0, lim});
        cur_pp  = pp;
        cur_max = lim;
    endtask

    initial begin : stimulus
        t_setting phase_setting [4];
        int       phase_send [4];
        int       phase_recv [4];
        phase_setting = '{CFG_CAMERA, CFG_RANDOM, CFG_HIGH, CFG_LOW};
        phase_send    = '{0, 80, 0, 15};
        phase_recv    = '{0, 0, 80, 15};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: zero principal point and zero focal reciprocals,
        // identity transform, limit 7000 mm.
        send_pixel(pixel_of(16'd1000, 12'd100, 12'd50, 8'h12, 8'h34, 8'h56));
        send_pixel(pixel_of(16'd7000, 12'hFFF, 12'd0, 8'hFF, 8'h00, 8'hA5));
        send_pixel(pixel_of(16'd7001, 12'd0, 12'hFFF, 8'h00, 8'hFF, 8'h5A));
        send_pixel(pixel_of(16'd0, 12'hFFF, 12'hFFF, 8'h80, 8'h01, 8'h7F));

        // Zero limit: only zero depth gets through.
        settle();
        apb_write(REG_MAX_DEPTH, 64'd0);
        cur_max = 16'd0;
        send_pixel(pixel_of(16'd0, 12'd640, 12'd480, 8'h11, 8'h22, 8'h33));
        send_pixel(pixel_of(16'd1, 12'd640, 12'd480, 8'h44, 8'h55, 8'h66));

        // Realistic camera: edges of the frame, the limit and both sides of it.
        settle();
        load_settings(CFG_CAMERA);
        send_pixel(pixel_of(16'd0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00));
        send_pixel(pixel_of(cur_max, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(pixel_of(cur_max + 16'd1, 12'd10, 12'd20, 8'h01, 8'h02, 8'h03));
        send_pixel(pixel_of(16'hFFFF, 12'd300, 12'd200, 8'hC0, 8'hDE, 8'hAD));
        send_pixel(pixel_of(16'd1500, cur_pp[15:4], cur_pp[31:20], 8'h9A, 8'hBC, 8'hDE));
        send_pixel(pixel_of(16'd1, 12'hFFF, 12'd0, 8'h5A, 8'hA5, 8'h3C));

        // Largest gains: deepest pixel at the far corner saturates.
        settle();
        load_settings(CFG_HIGH);
        send_pixel(pixel_of(16'hFFFF, 12'hFFF, 12'hFFF, 8'h01, 8'h80, 8'hFE));
        send_pixel(pixel_of(16'hFFFF, 12'd0, 12'd0, 8'h7E, 8'h81, 8'h18));
        send_pixel(pixel_of(16'd0, 12'd2048, 12'd2048, 8'hE7, 8'h24, 8'hDB));

        // Factors aimed at the negative rail: clips toward the negative rail too.
        settle();
        load_settings(CFG_LOW);
        send_pixel(pixel_of(cur_max, 12'd0, 12'd0, 8'h0F, 8'hF0, 8'h69));
        send_pixel(pixel_of(cur_max + 16'd1, 12'hFFF, 12'hFFF, 8'h96, 8'hC3, 8'h3C));
        send_pixel(pixel_of(16'd0, 12'hFFF, 12'd0, 8'hAA, 8'h55, 8'hCC));

        // Random phases, each under its own register setting and idle pattern.
        // Halfway through each phase, hold the sender until the pipeline is empty.
        for (int ph = 0; ph < 4; ph++) begin
            settle();
            load_settings(phase_setting[ph]);
            send_idle   = phase_send[ph];
            recv_stall <= phase_recv[ph];
            for (int i = 0; i < PHASE_PIXELS; i++) begin
                if (i == PHASE_PIXELS / 2) settle();
                send_pixel(random_pixel());
            end
        end

        settle();
        $display("Covered %0d pixels under reset, zero-limit, camera, random and extreme settings,",
                 pixels_sent);
        $display("with four idle patterns: %0d points compared, %0d invalid, %0d saturated.",
                 points, invalid_points, clipped_points);
        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
